@@ hw/rtl/qvr_pkg.sv @@
// qvr_pkg: shared constants for the quaternion vector rotation pipeline.
// No dependencies; imported by quaternion_vector_rotate.

package qvr_pkg;

   // default component width, vector Q4.(W-4), quaternion Q2.(W-2)
   localparam int COMPONENT_WIDTH_DEF = 16;

   // register stages from input to output
   localparam int NUM_STAGES = 6;

   // axis index tables for the cross product: (u x v)_i = u[n] v[p] - u[p] v[n]
   localparam int NEXT_IDX [3] = '{1, 2, 0};
   localparam int PREV_IDX [3] = '{2, 0, 1};

endpackage

@@ hw/rtl/quaternion_vector_rotate.sv @@
// quaternion_vector_rotate: six-stage pipeline that rotates a fixed-point
// 3-vector by a fixed-point quaternion; depends on qvr_pkg.
//
// Usage:
// The req_ channel carries one vector (vec_x/y/z, signed Q4.(W-4)) and one
// quaternion (quat_w/x/y/z, signed Q2.(W-2)) per transaction. The rsp_
// channel returns rot_x/y/z = 2(u.v)u + (w*w - u.u)v + 2w(u x v), rounded
// to nearest (ties up) and saturated to Q4.(W-4); rsp_clipped is set when
// any of the three components saturated. The quaternion is not normalized.
// Throughput is one transaction per cycle while the output is not stalled,
// set by the fully pipelined multiplier stages (13 products, then 18 split
// partial products). Each stage has its own valid bit, so bubbles close up
// when rsp_ready is low and req_ready stays high while any stage is empty;
// with all six stages full and rsp_ready low, req_ready drops and the
// pipeline holds. Synchronous reset clears the valid bits only; no
// transaction survives it. There is no configuration and no state kept
// between transactions.

module quaternion_vector_rotate
   import qvr_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_z,
   output logic                              rsp_clipped
);

   localparam int W     = COMPONENT_WIDTH;
   localparam int P_W   = 2 * W;         // single product
   localparam int S_W   = 2 * W + 2;     // sum of up to four products
   localparam int LO_W  = W + 1;         // low split of a sum, unsigned
   localparam int PL_W  = 2 * W + 2;     // low partial product
   localparam int PH_W  = 2 * W + 1;     // high partial product
   localparam int T_W   = 2 * W + 5;     // sum of weighted partial products
   localparam int ACC_W = 3 * W + 5;     // exact accumulator
   localparam int DROP  = 2 * (W - 2);   // fraction bits removed at rounding
   localparam int R_W   = ACC_W - DROP;  // rounded value before saturation
   localparam int LAST  = NUM_STAGES - 1;

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (DROP - 1);

   // ---------------- handshake and valid bits ----------------
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] load;

   always_comb begin
      load[LAST] = !vld_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (load[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (load[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------- stage 0: all pairwise products ----------------
   logic signed [W-1:0] vec_in [3];
   logic signed [W-1:0] uq_in  [3];

   assign vec_in[0] = req_vec_x;
   assign vec_in[1] = req_vec_y;
   assign vec_in[2] = req_vec_z;
   assign uq_in[0]  = req_quat_x;
   assign uq_in[1]  = req_quat_y;
   assign uq_in[2]  = req_quat_z;

   logic signed [P_W-1:0] uv_in [3];
   logic signed [P_W-1:0] uu_in [3];
   logic signed [P_W-1:0] xa_in [3];
   logic signed [P_W-1:0] xb_in [3];
   logic signed [P_W-1:0] ww_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         uv_in[i] = P_W'(uq_in[i]) * P_W'(vec_in[i]);
         uu_in[i] = P_W'(uq_in[i]) * P_W'(uq_in[i]);
         xa_in[i] = P_W'(uq_in[NEXT_IDX[i]]) * P_W'(vec_in[PREV_IDX[i]]);
         xb_in[i] = P_W'(uq_in[PREV_IDX[i]]) * P_W'(vec_in[NEXT_IDX[i]]);
      end
      ww_in = P_W'(req_quat_w) * P_W'(req_quat_w);
   end

   logic signed [P_W-1:0] uv_ff [3];
   logic signed [P_W-1:0] uu_ff [3];
   logic signed [P_W-1:0] xa_ff [3];
   logic signed [P_W-1:0] xb_ff [3];
   logic signed [P_W-1:0] ww_ff;
   logic signed [W-1:0]   vec0_ff [3];
   logic signed [W-1:0]   uq0_ff  [3];
   logic signed [W-1:0]   w0_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         uv_ff   <= uv_in;
         uu_ff   <= uu_in;
         xa_ff   <= xa_in;
         xb_ff   <= xb_in;
         ww_ff   <= ww_in;
         vec0_ff <= vec_in;
         uq0_ff  <= uq_in;
         w0_ff   <= req_quat_w;
      end
   end

   // ---------------- stage 1: dot, scale and cross sums ----------------
   logic signed [S_W-1:0] dot_in;
   logic signed [S_W-1:0] scl_in;
   logic signed [S_W-1:0] crs_in [3];

   always_comb begin
      dot_in = S_W'(uv_ff[0]) + S_W'(uv_ff[1]) + S_W'(uv_ff[2]);
      scl_in = S_W'(ww_ff) - S_W'(uu_ff[0]) - S_W'(uu_ff[1]) - S_W'(uu_ff[2]);
      for (int i = 0; i < 3; i++) begin
         crs_in[i] = S_W'(xa_ff[i]) - S_W'(xb_ff[i]);
      end
   end

   logic signed [S_W-1:0] dot_ff;
   logic signed [S_W-1:0] scl_ff;
   logic signed [S_W-1:0] crs_ff [3];
   logic signed [W-1:0]   vec1_ff [3];
   logic signed [W-1:0]   uq1_ff  [3];
   logic signed [W-1:0]   w1_ff;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         dot_ff  <= dot_in;
         scl_ff  <= scl_in;
         crs_ff  <= crs_in;
         vec1_ff <= vec0_ff;
         uq1_ff  <= uq0_ff;
         w1_ff   <= w0_ff;
      end
   end

   // ---------------- stage 2: split second-level products ----------------
   // each wide sum is cut into an unsigned low half and a signed high half
   // so that no multiplier exceeds (W+2) x W bits
   logic signed [PL_W-1:0] pl_d_in [3];
   logic signed [PL_W-1:0] pl_s_in [3];
   logic signed [PL_W-1:0] pl_c_in [3];
   logic signed [PH_W-1:0] ph_d_in [3];
   logic signed [PH_W-1:0] ph_s_in [3];
   logic signed [PH_W-1:0] ph_c_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pl_d_in[i] = PL_W'($signed({1'b0, dot_ff[LO_W-1:0]})) * PL_W'(uq1_ff[i]);
         pl_s_in[i] = PL_W'($signed({1'b0, scl_ff[LO_W-1:0]})) * PL_W'(vec1_ff[i]);
         pl_c_in[i] = PL_W'($signed({1'b0, crs_ff[i][LO_W-1:0]})) * PL_W'(w1_ff);
         ph_d_in[i] = PH_W'($signed(dot_ff[S_W-1:LO_W])) * PH_W'(uq1_ff[i]);
         ph_s_in[i] = PH_W'($signed(scl_ff[S_W-1:LO_W])) * PH_W'(vec1_ff[i]);
         ph_c_in[i] = PH_W'($signed(crs_ff[i][S_W-1:LO_W])) * PH_W'(w1_ff);
      end
   end

   logic signed [PL_W-1:0] pl_d_ff [3];
   logic signed [PL_W-1:0] pl_s_ff [3];
   logic signed [PL_W-1:0] pl_c_ff [3];
   logic signed [PH_W-1:0] ph_d_ff [3];
   logic signed [PH_W-1:0] ph_s_ff [3];
   logic signed [PH_W-1:0] ph_c_ff [3];

   always_ff @(posedge clock) begin
      if (load[2]) begin
         pl_d_ff <= pl_d_in;
         pl_s_ff <= pl_s_in;
         pl_c_ff <= pl_c_in;
         ph_d_ff <= ph_d_in;
         ph_s_ff <= ph_s_in;
         ph_c_ff <= ph_c_in;
      end
   end

   // ---------------- stage 3: weighted partial sums ----------------
   logic signed [T_W-1:0] lo_sum_in [3];
   logic signed [T_W-1:0] hi_sum_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo_sum_in[i] = (T_W'(pl_d_ff[i]) <<< 1) + T_W'(pl_s_ff[i])
                        + (T_W'(pl_c_ff[i]) <<< 1);
         hi_sum_in[i] = (T_W'(ph_d_ff[i]) <<< 1) + T_W'(ph_s_ff[i])
                        + (T_W'(ph_c_ff[i]) <<< 1);
      end
   end

   logic signed [T_W-1:0] lo_sum_ff [3];
   logic signed [T_W-1:0] hi_sum_ff [3];

   always_ff @(posedge clock) begin
      if (load[3]) begin
         lo_sum_ff <= lo_sum_in;
         hi_sum_ff <= hi_sum_in;
      end
   end

   // ---------------- stage 4: exact accumulate and round ----------------
   logic signed [ACC_W-1:0] acc;
   logic signed [R_W-1:0]   rnd_in [3];

   always_comb begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         acc = (ACC_W'(hi_sum_ff[i]) <<< LO_W) + ACC_W'(lo_sum_ff[i]) + HALF;
         rnd_in[i] = $signed(acc[ACC_W-1:DROP]);
      end
   end

   logic signed [R_W-1:0] rnd_ff [3];

   always_ff @(posedge clock) begin
      if (load[4]) begin
         rnd_ff <= rnd_in;
      end
   end

   // ---------------- stage 5: saturate into the output register ----------------
   logic signed [W-1:0] rot_in [3];
   logic [2:0]          sat;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // in range when every bit above the result's sign bit matches it
         sat[i] = !((&rnd_ff[i][R_W-1:W-1]) || !(|rnd_ff[i][R_W-1:W-1]));
         if (sat[i]) begin
            rot_in[i] = {rnd_ff[i][R_W-1], {(W-1){~rnd_ff[i][R_W-1]}}};
         end else begin
            rot_in[i] = rnd_ff[i][W-1:0];
         end
      end
   end

   logic signed [W-1:0] rot_ff [3];
   logic                clip_ff;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         rot_ff  <= rot_in;
         clip_ff <= |sat;
      end
   end

   assign rsp_rot_x   = rot_ff[0];
   assign rsp_rot_y   = rot_ff[1];
   assign rsp_rot_z   = rot_ff[2];
   assign rsp_clipped = clip_ff;

`ifndef SYNTHESIS
   localparam logic signed [W-1:0] ROT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] ROT_MIN = {1'b1, {(W-1){1'b0}}};

   // an accepted transaction always lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transaction missing from stage 0");

   // a flagged result has at least one component pinned at a rail
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         (rsp_rot_x == ROT_MAX || rsp_rot_x == ROT_MIN ||
          rsp_rot_y == ROT_MAX || rsp_rot_y == ROT_MIN ||
          rsp_rot_z == ROT_MAX || rsp_rot_z == ROT_MIN))
      else $error("clipped set without a saturated component");

   // a stalled output keeps the stage behind it occupied
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && !rsp_ready && vld_ff[LAST-1] |=> vld_ff[LAST-1])
      else $error("transaction dropped behind stalled output");
`endif

endmodule

@@ tb/quaternion_vector_rotate_test.sv @@
// quaternion_vector_rotate_test: self-checking bench for the quaternion vector rotation pipeline.
// A scoreboard class predicts each rotation exactly; uses qvr_pkg and quaternion_vector_rotate.

`timescale 1ns / 1ps

module quaternion_vector_rotate_test;
   import qvr_pkg::*;

   localparam int W            = COMPONENT_WIDTH_DEF;
   localparam int DROP         = 2 * (W - 2);
   localparam int ACC_W        = 4 * W + 8;
   localparam int RANDOM_ITEMS = 1250;

   typedef logic signed [W-1:0]     comp_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   localparam comp_type F_MAX = {1'b0, {(W-1){1'b1}}};
   localparam comp_type F_MIN = {1'b1, {(W-1){1'b0}}};
   localparam comp_type Q_ONE = comp_type'(1 << (W - 2));
   localparam comp_type V_ONE = comp_type'(1 << (W - 4));
   // cosine of 45 degrees in Q2.14
   localparam comp_type Q_C45 = comp_type'(11585);

   typedef struct packed {
      comp_type vx, vy, vz;
      comp_type qw, qx, qy, qz;
   } rot_req_type;

   typedef struct packed {
      comp_type x, y, z;
      logic     clipped;
   } rot_rsp_type;

   class rotation_scoreboard;
      rot_rsp_type rotations_due[$];
      int errors;
      int results_checked;
      int clipped_seen;

      function new();
         errors = 0;
         results_checked = 0;
         clipped_seen = 0;
      endfunction

      // exact v' = 2(u.v)u + (w^2 - u.u)v + 2w(u x v), round half up, saturate
      function rot_rsp_type rotate_vector(rot_req_type r);
         acc_type v[3];
         acc_type u[3];
         acc_type w, dot, norm_u, acc, rnd, max_v, min_v;
         comp_type comp[3];
         rot_rsp_type res;
         v[0] = r.vx;
         v[1] = r.vy;
         v[2] = r.vz;
         u[0] = r.qx;
         u[1] = r.qy;
         u[2] = r.qz;
         w = r.qw;
         max_v = (acc_type'(1) <<< (W - 1)) - 1;
         min_v = -max_v - 1;
         dot = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
         norm_u = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
         res.clipped = 1'b0;
         for (int i = 0; i < 3; i++) begin
            acc = 2 * dot * u[i] + (w * w - norm_u) * v[i]
                + 2 * w * (u[NEXT_IDX[i]] * v[PREV_IDX[i]] - u[PREV_IDX[i]] * v[NEXT_IDX[i]]);
            rnd = (acc + (acc_type'(1) <<< (DROP - 1))) >>> DROP;
            if (rnd > max_v) begin
               rnd = max_v;
               res.clipped = 1'b1;
            end else if (rnd < min_v) begin
               rnd = min_v;
               res.clipped = 1'b1;
            end
            comp[i] = comp_type'(rnd);
         end
         res.x = comp[0];
         res.y = comp[1];
         res.z = comp[2];
         return res;
      endfunction

      function void queue_rotation(rot_req_type r);
         rotations_due.push_back(rotate_vector(r));
      endfunction

      function void compare_field(string name, comp_type want, comp_type got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_rotation(rot_rsp_type got);
         rot_rsp_type want;
         if (rotations_due.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none, actual %0d %0d %0d %0d",
                     $time, got.x, got.y, got.z, got.clipped);
            errors++;
            return;
         end
         want = rotations_due.pop_front();
         results_checked++;
         if (got.clipped)
            clipped_seen++;
         compare_field("rot_x", want.x, got.x);
         compare_field("rot_y", want.y, got.y);
         compare_field("rot_z", want.z, got.z);
         compare_field("clipped", comp_type'(want.clipped), comp_type'(got.clipped));
      endfunction
   endclass

   logic     clock      = 1'b0;
   logic     reset      = 1'b1;
   logic     req_valid  = 1'b0;
   logic     req_ready;
   comp_type req_vec_x  = '0;
   comp_type req_vec_y  = '0;
   comp_type req_vec_z  = '0;
   comp_type req_quat_w = '0;
   comp_type req_quat_x = '0;
   comp_type req_quat_y = '0;
   comp_type req_quat_z = '0;
   logic     rsp_valid;
   logic     rsp_ready  = 1'b0;
   comp_type rsp_rot_x;
   comp_type rsp_rot_y;
   comp_type rsp_rot_z;
   logic     rsp_clipped;

   rotation_scoreboard board = new();
   int items_sent = 0;
   int rx_cycle = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   quaternion_vector_rotate #(
      .COMPONENT_WIDTH(W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_vec_x  (req_vec_x),
      .req_vec_y  (req_vec_y),
      .req_vec_z  (req_vec_z),
      .req_quat_w (req_quat_w),
      .req_quat_x (req_quat_x),
      .req_quat_y (req_quat_y),
      .req_quat_z (req_quat_z),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_rot_x  (rsp_rot_x),
      .rsp_rot_y  (rsp_rot_y),
      .rsp_rot_z  (rsp_rot_z),
      .rsp_clipped(rsp_clipped)
   );

   function automatic rot_req_type make_request(comp_type vx, comp_type vy, comp_type vz,
                                                comp_type qw, comp_type qx, comp_type qy,
                                                comp_type qz);
      rot_req_type r;
      r.vx = vx;
      r.vy = vy;
      r.vz = vz;
      r.qw = qw;
      r.qx = qx;
      r.qy = qy;
      r.qz = qz;
      return r;
   endfunction

   function automatic comp_type corner_value();
      case ($urandom_range(0, 7))
         0: return F_MAX;
         1: return F_MIN;
         2: return '0;
         3: return '1;
         4: return Q_ONE;
         5: return -Q_ONE;
         6: return comp_type'(1);
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic rot_req_type random_request();
      comp_type f[7];
      real qd[4];
      real norm;
      int kind;
      kind = $urandom_range(0, 99);
      for (int k = 0; k < 7; k++)
         f[k] = comp_type'($urandom);
      if (kind < 50) begin
         // unit quaternion, vector kept mostly inside range
         norm = 0.0;
         for (int k = 0; k < 4; k++) begin
            qd[k] = $itor(f[3 + k]);
            norm = norm + qd[k] * qd[k];
         end
         norm = $sqrt(norm);
         if (norm > 0.0)
            for (int k = 0; k < 4; k++)
               f[3 + k] = comp_type'(int'(qd[k] / norm * $itor(Q_ONE)));
         for (int k = 0; k < 3; k++)
            f[k] = comp_type'(int'($urandom_range(0, 36000)) - 18000);
      end else if (kind < 85 && kind >= 70) begin
         // tiny values exercise rounding near zero
         for (int k = 0; k < 7; k++)
            f[k] = comp_type'(int'($urandom_range(0, 128)) - 64);
      end else if (kind >= 85) begin
         for (int k = 0; k < 7; k++)
            f[k] = corner_value();
      end
      return make_request(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
   endfunction

   // called at a rising edge; returns at the edge where the transaction is accepted
   task automatic drive_request(input rot_req_type r);
      req_valid  <= 1'b1;
      req_vec_x  <= r.vx;
      req_vec_y  <= r.vy;
      req_vec_z  <= r.vz;
      req_quat_w <= r.qw;
      req_quat_x <= r.qx;
      req_quat_y <= r.qy;
      req_quat_z <= r.qz;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.queue_rotation(r);
      items_sent++;
   endtask

   task automatic idle_gap(input int cycles);
      req_valid  <= 1'b0;
      req_vec_x  <= comp_type'($urandom);
      req_quat_w <= comp_type'($urandom);
      repeat (cycles)
         @(posedge clock);
   endtask

   // receiver: stall pattern rotates through four modes selected by rx_cycle[9:8]
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_rotation(rot_rsp_type'{rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_clipped});
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_ready <= (rx_cycle[2:0] == 3'd0);
         default: rsp_ready <= ((rx_cycle % 24) < 4);
      endcase
   end

   initial begin
      int burst;
      int gap;
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;

      // identity keeps the vector, including the range ends
      drive_request(make_request(V_ONE, -V_ONE, comp_type'(12345), Q_ONE, '0, '0, '0));
      drive_request(make_request(F_MAX, F_MAX, F_MAX, Q_ONE, '0, '0, '0));
      drive_request(make_request(F_MIN, F_MIN, F_MIN, Q_ONE, '0, '0, '0));
      // zero quaternion collapses the vector
      drive_request(make_request(F_MAX, F_MIN, comp_type'(77), '0, '0, '0, '0));
      // quarter turns about z and about x, half turn about x
      drive_request(make_request(V_ONE, '0, '0, Q_C45, '0, '0, Q_C45));
      drive_request(make_request(comp_type'(1000), comp_type'(2000), comp_type'(-3000),
                                 '0, Q_ONE, '0, '0));
      drive_request(make_request('0, V_ONE, -V_ONE, -Q_C45, Q_C45, '0, '0));
      // exact half lsb: ties go toward plus infinity
      drive_request(make_request(comp_type'(8192), '0, '0, '0, comp_type'(128), '0, '0));
      drive_request(make_request(comp_type'(-8192), '0, '0, '0, comp_type'(128), '0, '0));
      // non-unit quaternions, saturation in both directions
      drive_request(make_request(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX));
      drive_request(make_request(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN));
      drive_request(make_request(F_MAX, F_MIN, comp_type'(1), F_MIN, '0, '0, '0));
      drive_request(make_request(F_MIN, F_MAX, '0, '0, F_MIN, '0, '0));
      drive_request(make_request(V_ONE, V_ONE, V_ONE, Q_ONE >>> 1, '0, '0, '0));
      drive_request(make_request('1, '1, '1, '1, '1, '1, '1));
      drive_request(make_request(F_MAX, '0, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN));
      idle_gap(3);

      burst = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 32);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
               idle_gap(gap);
         end
         drive_request(random_request());
         burst--;
      end
      req_valid <= 1'b0;

      while (board.rotations_due.size() != 0)
         @(posedge clock);
      repeat (NUM_STAGES + 4)
         @(posedge clock);

      $display("sent %0d rotations (directed and random), checked %0d results, %0d saturated",
               items_sent, board.results_checked, board.clipped_seen);
      $display("receiver cycled through free-running, random and long stall patterns");
      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #3_000_000;
      $display("timeout with %0d results outstanding", board.rotations_due.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/qvr_pkg.sv
hw/rtl/quaternion_vector_rotate.sv
tb/quaternion_vector_rotate_test.sv
